>>> hdl/sha1_pkg.sv
package sha1_pkg;

	localparam int unsigned BLK_BITS  = 512;
	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned NUM_HASH  = 5;
	localparam int unsigned NUM_ROUND = 80;

	localparam logic [7:0]  PAD_BYTE  = 8'h80;
	localparam logic [5:0]  LEN_POS   = 6'd56;
	localparam logic [5:0]  LAST_POS  = 6'd63;
	localparam logic [6:0]  LAST_RND  = 7'd79;

	localparam logic [31:0] K_ROUND0 = 32'h5A827999;
	localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT [NUM_HASH] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_FINAL = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// controls from the sequencer to the message schedule
	typedef struct packed {
		logic       byte_en;
		logic       word_en;
		logic [7:0] byte_in;
	} sched_ctrl_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (WORD_BITS - n));
	endfunction

	// round constant by round number
	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20)      k = K_ROUND0;
		else if (r < 7'd40) k = K_ROUND1;
		else if (r < 7'd60) k = K_ROUND2;
		else                k = K_ROUND3;
		round_k = k;
	endfunction

	// round logic function by round number
	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20)      f = (b & c) | (~b & d);
		else if (r < 7'd40) f = b ^ c ^ d;
		else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
		else                f = b ^ c ^ d;
		round_f = f;
	endfunction

endpackage

>>> hdl/sha1_msg_sched.sv
module sha1_msg_sched
	import sha1_pkg::*;
(
	input  logic        clk,
	input  sched_ctrl_t ctrl,
	output logic [31:0] w_head
);

	// 64-byte window: filled a byte at a time, then slid a word per round
	logic [BLK_BITS-1:0] blk_q;
	logic [31:0]         w_new;

	assign w_head = blk_q[511 -: 32];

	// next schedule word from the taps at distances 0, 2, 8 and 13
	assign w_new = rotl(blk_q[511 -: 32] ^ blk_q[447 -: 32] ^ blk_q[255 -: 32]
		^ blk_q[95 -: 32], 1);

	// window shift
	always_ff @(posedge clk) begin
		if (ctrl.byte_en) begin
			blk_q <= {blk_q[BLK_BITS-9:0], ctrl.byte_in};
		end else if (ctrl.word_en) begin
			blk_q <= {blk_q[BLK_BITS-33:0], w_new};
		end
	end

endmodule

>>> hdl/sha1_hash_engine.sv
// channel | handshake                   | payload                      | dir
// item    | item_valid, item_ready      | data_byte, has_byte, last    | in
// digest  | digest_valid, digest_ready  | digest_word0 .. digest_word4 | out
//
// every 64th message byte starts a compression (80 rounds on one round unit plus the hash
// update), during which no new item is taken
// the last item adds a pad sweep of one byte per cycle to the block end and a compression;
// when the length no longer fits, a second full-block sweep and compression follow
// item_ready is low while a block compresses, while padding and while a digest waits
// reset loads the initial hash words and clears the bit count; no clearing pass
module sha1_hash_engine
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word0,
	output logic [31:0] digest_word1,
	output logic [31:0] digest_word2,
	output logic [31:0] digest_word3,
	output logic [31:0] digest_word4
);

	state_t      state_q;
	logic [31:0] hash_q [NUM_HASH];
	logic [63:0] bit_count_q;
	logic [5:0]  fill_q;
	logic [6:0]  rnd_q;
	logic        in_pad_q;
	logic        mark_q;
	logic        len_ok_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	sched_ctrl_t sched_ctrl;
	logic [31:0] w_head;
	logic [31:0] t_sum;
	logic [63:0] len_shifted;
	logic [7:0]  pad_byte;
	logic        item_acc;
	logic        digest_acc;

	assign item_ready   = (state_q == ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign item_acc     = item_valid & item_ready;
	assign digest_acc   = digest_valid & digest_ready;

	assign digest_word0 = hash_q[0];
	assign digest_word1 = hash_q[1];
	assign digest_word2 = hash_q[2];
	assign digest_word3 = hash_q[3];
	assign digest_word4 = hash_q[4];

	// pad byte: marker first, then zeros, length bytes big-endian at the tail
	assign len_shifted = bit_count_q >> {~fill_q[2:0], 3'b000};
	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_ok_q && (fill_q >= LEN_POS)) begin
			pad_byte = len_shifted[7:0];
		end else begin
			pad_byte = '0;
		end
	end

	// schedule controls
	always_comb begin
		sched_ctrl.byte_en = (item_acc && has_byte) || (state_q == ST_PAD);
		sched_ctrl.word_en = (state_q == ST_ROUND);
		sched_ctrl.byte_in = (state_q == ST_PAD) ? pad_byte : data_byte;
	end

	sha1_msg_sched u_sched (
		.clk    (clk),
		.ctrl   (sched_ctrl),
		.w_head (w_head)
	);

	// shared round adder
	assign t_sum = rotl(a_q, 5) + round_f(rnd_q, b_q, c_q, d_q) + e_q
		+ round_k(rnd_q) + w_head;

	// working variables: load at block start, one round per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end else begin
			a_q <= hash_q[0];
			b_q <= hash_q[1];
			c_q <= hash_q[2];
			d_q <= hash_q[3];
			e_q <= hash_q[4];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hash_q      <= H_INIT;
			bit_count_q <= '0;
			fill_q      <= '0;
			rnd_q       <= '0;
			in_pad_q    <= 1'b0;
			mark_q      <= 1'b0;
			len_ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (has_byte) begin
							bit_count_q <= bit_count_q + 64'd8;
							fill_q      <= fill_q + 6'd1;
						end
						if (has_byte && (fill_q == LAST_POS)) begin
							in_pad_q <= last;
							state_q  <= ST_ROUND;
						end else if (last) begin
							in_pad_q <= 1'b1;
							state_q  <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					if (!mark_q && (fill_q < LEN_POS)) begin
						len_ok_q <= 1'b1;
					end
					fill_q <= fill_q + 6'd1;
					if (fill_q == LAST_POS) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (rnd_q == LAST_RND) begin
						rnd_q   <= '0;
						state_q <= ST_FINAL;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_FINAL: begin
					hash_q[0] <= hash_q[0] + a_q;
					hash_q[1] <= hash_q[1] + b_q;
					hash_q[2] <= hash_q[2] + c_q;
					hash_q[3] <= hash_q[3] + d_q;
					hash_q[4] <= hash_q[4] + e_q;
					if (!in_pad_q) begin
						state_q <= ST_IDLE;
					end else if (len_ok_q) begin
						state_q <= ST_OUT;
					end else begin
						len_ok_q <= 1'b1;
						state_q  <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (digest_ready) begin
						hash_q      <= H_INIT;
						bit_count_q <= '0;
						fill_q      <= '0;
						in_pad_q    <= 1'b0;
						mark_q      <= 1'b0;
						len_ok_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fill position tracks the byte count between items
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fill_q == bit_count_q[8:3]))
		else $error("fill position out of step with bit count");

	// the hash update follows exactly the last round
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |-> ($past(state_q) == ST_ROUND && $past(rnd_q) == LAST_RND))
		else $error("hash update without a full round sweep");

	// a taken digest restarts the message state
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_acc |=> (bit_count_q == '0 && hash_q[0] == H_INIT[0] && !in_pad_q))
		else $error("message state not restarted after digest");

	// the round counter only moves while compressing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (rnd_q == '0))
		else $error("round counter left running");

endmodule
